>>> hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/i2crd_pkg.sv
package i2crd_pkg;
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_ADDR_W, PH_ACK1, PH_ACK1_NACK, PH_REG, PH_ACK2,
        PH_RSTART, PH_ADDR_R, PH_ACK3, PH_READ, PH_RACK, PH_STOP, PH_STOP_ERR
    } phase_t;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;
    localparam logic [15:0] DELAY_RESET = 16'd2;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic       req_type;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] read_len;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       done_res;
        logic       nack_error;
    } out_word_t;
endpackage

>>> hdl/i2crd_if.sv
interface i2crd_in_if import i2crd_pkg::*; ;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2crd_out_if import i2crd_pkg::*; ;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/i2crd_queue.sv
module i2crd_queue import i2crd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_word_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output in_word_t pop_data
);
    in_word_t mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0] cnt_reg;

    assign full = cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= wp_reg + 1'b1;
            if (pop && !empty)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(QDEPTH)+1)'(push && !full)
                       - ($clog2(QDEPTH)+1)'(pop && !empty);
        end
    end
endmodule

>>> hdl/i2crd_seq.sv
module i2crd_seq import i2crd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] delay_ticks,
    input  logic        go,
    input  in_word_t    word,
    output out_word_t   res
);
    phase_t phase_reg, phase_next;
    logic [2:0] step_reg, step_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] sh_reg, sh_next, left_reg, left_next;
    logic [15:0] wait_reg, wait_next, wnext, lim;
    logic [6:0] dev_reg, dev_next;
    logic [7:0] ra_reg, ra_next;
    logic scl_reg, scl_next, sda_reg, sda_next;
    logic [3:0] bc1;

    assign lim = (delay_ticks == '0) ? 16'd1 : delay_ticks;
    assign wnext = wait_reg + 16'd1;
    assign bc1 = bit_reg + 4'd1;

    // line drive follows the state after an update
    always_comb
    begin
        scl_next = 1'b1;
        sda_next = 1'b1;
        unique case (phase_next)
            PH_START, PH_RSTART: sda_next = step_next == 3'd0;
            PH_ADDR_W, PH_REG, PH_ADDR_R:
            begin
                scl_next = step_next == 3'd1;
                sda_next = (step_next == 3'd2 && bit_next == 4'd7) ? 1'b1 : sh_next[7];
            end
            PH_ACK1, PH_ACK1_NACK, PH_ACK2, PH_ACK3, PH_READ:
                scl_next = step_next == 3'd0;
            PH_RACK:
            begin
                scl_next = step_next == 3'd1;
                sda_next = !(left_next > 8'd1);
            end
            PH_STOP, PH_STOP_ERR:
            begin
                scl_next = step_next != 3'd0;
                sda_next = step_next != 3'd0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg; step_next = step_reg; bit_next = bit_reg;
        sh_next = sh_reg; left_next = left_reg; wait_next = wait_reg;
        dev_next = dev_reg; ra_next = ra_reg;
        res = '0;
        res.scl_out = scl_reg;
        res.sda_out = sda_reg;
        if (go && word.req_type == REQ_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                dev_next = word.dev_addr; ra_next = word.reg_addr;
                left_next = word.read_len; phase_next = PH_START;
                step_next = '0; bit_next = '0; sh_next = '0; wait_next = '0;
            end
        end
        else if (go && phase_reg != PH_IDLE)
        begin
            wait_next = wnext;
            if (wnext >= lim || wnext == '0)
            begin
                wait_next = '0;
                unique case (phase_reg)
                    PH_START, PH_RSTART:
                        if (step_reg == 3'd0) step_next = 3'd1;
                        else
                        begin
                            phase_next = (phase_reg == PH_START) ? PH_ADDR_W : PH_ADDR_R;
                            step_next = '0; bit_next = '0;
                            sh_next = {dev_reg, phase_reg == PH_RSTART};
                        end
                    PH_ADDR_W, PH_REG, PH_ADDR_R:
                        if (step_reg < 3'd2) step_next = step_reg + 3'd1;
                        else
                        begin
                            sh_next = {sh_reg[6:0], 1'b0};
                            bit_next = bc1;
                            step_next = '0;
                            if (bc1 >= 4'd8)
                            begin
                                bit_next = '0;
                                phase_next = (phase_reg == PH_ADDR_W) ? PH_ACK1 :
                                             (phase_reg == PH_REG) ? PH_ACK2 : PH_ACK3;
                            end
                        end
                    PH_ACK1:
                        if (step_reg == 3'd0)
                        begin
                            step_next = 3'd1;
                            if (word.sda_in) phase_next = PH_ACK1_NACK;
                        end
                        else
                        begin
                            phase_next = PH_REG; step_next = '0; bit_next = '0;
                            sh_next = ra_reg;
                        end
                    PH_ACK1_NACK:
                    begin
                        phase_next = PH_STOP_ERR; step_next = '0;
                    end
                    PH_ACK2:
                        if (step_reg == 3'd0) step_next = 3'd1;
                        else
                        begin
                            phase_next = PH_RSTART; step_next = '0;
                        end
                    PH_ACK3:
                        if (step_reg == 3'd0) step_next = 3'd1;
                        else if (left_reg == '0)
                        begin
                            phase_next = PH_STOP; step_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_READ; step_next = '0; bit_next = '0;
                            sh_next = '0;
                        end
                    PH_READ:
                        if (step_reg == 3'd0)
                        begin
                            sh_next = {sh_reg[6:0], word.sda_in};
                            bit_next = bc1;
                            if (bc1 >= 4'd8)
                            begin
                                res.rx_byte = sh_next;
                                res.byte_valid = 1'b1;
                                res.last_byte = left_reg == 8'd1;
                            end
                            step_next = 3'd1;
                        end
                        else if (bit_reg >= 4'd8)
                        begin
                            phase_next = PH_RACK; step_next = '0;
                        end
                        else step_next = '0;
                    PH_RACK:
                        if (step_reg < 3'd2) step_next = step_reg + 3'd1;
                        else
                        begin
                            left_next = left_reg - 8'd1;
                            step_next = '0;
                            if (left_next == '0) phase_next = PH_STOP;
                            else
                            begin
                                phase_next = PH_READ; bit_next = '0; sh_next = '0;
                            end
                        end
                    PH_STOP, PH_STOP_ERR:
                        if (step_reg == 3'd0) step_next = 3'd1;
                        else
                        begin
                            res.done_res = 1'b1;
                            res.nack_error = phase_reg == PH_STOP_ERR;
                            phase_next = PH_IDLE; step_next = '0; bit_next = '0;
                        end
                    default:
                    begin
                        phase_next = PH_IDLE; step_next = '0;
                    end
                endcase
            end
        end
        res.busy_res = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; step_reg <= '0; bit_reg <= '0; sh_reg <= '0;
            left_reg <= '0; wait_reg <= '0; dev_reg <= '0; ra_reg <= '0;
            scl_reg <= 1'b1; sda_reg <= 1'b1;
        end
        else if (go)
        begin
            phase_reg <= phase_next; step_reg <= step_next; bit_reg <= bit_next;
            sh_reg <= sh_next; left_reg <= left_next; wait_reg <= wait_next;
            dev_reg <= dev_next; ra_reg <= ra_next;
            scl_reg <= scl_next; sda_reg <= sda_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_idle_released, phase_reg == PH_IDLE, scl_reg && sda_reg, "idle drives line")
    `ASSERT_NEXT(a_done_idle, go && res.done_res, phase_reg == PH_IDLE, "done not idle")
    `ASSERT_CLK(a_err_done, !res.nack_error || res.done_res, "error without done")
endmodule

>>> hdl/i2c_master_register_read_unit.sv
// A word is accepted into the input queue; its result is registered into the output register when the
// word is popped. Throughput: one word per cycle while the output is taken; the sequencer steps once per
// delay_ticks tick words (at least one). A two-entry input queue decouples intake from the sequencer,
// and one output register holds the result until taken.
// Reset (rst_n, async): sequencer idle, lines released, delay_ticks = 2.
module i2c_master_register_read_unit import i2crd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    i2crd_in_if.sink    in_ch,
    i2crd_out_if.source out_ch
);
    logic [15:0] delay_reg;
    logic full, empty, go;
    in_word_t qword;
    out_word_t res, obuf_reg;
    logic ovalid_reg;

    assign in_ch.ready = !full;
    assign go = !empty && (!ovalid_reg || out_ch.ready);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = obuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg_we)
            delay_reg <= cfg_wdata;
    end

    i2crd_queue u_q (
        .clk(clk), .rst_n(rst_n), .push(in_ch.valid), .push_data(in_ch.data),
        .full(full), .pop(go), .empty(empty), .pop_data(qword)
    );

    i2crd_seq u_seq (
        .clk(clk), .rst_n(rst_n), .delay_ticks(delay_reg), .go(go),
        .word(qword), .res(res)
    );

    always_ff @(posedge clk)
    begin
        if (go)
            obuf_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (go)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import i2crd_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    i2crd_in_if in_ch();
    i2crd_out_if out_ch();

    i2c_master_register_read_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Line sequencer predictor with its own copy of state and delay setting.
    class i2c_read_scoreboard;
        logic [15:0] hold_ticks;
        phase_t      ph;
        logic [2:0]  step;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [7:0]  remaining;
        logic [15:0] hold_cnt;
        logic [6:0]  dev;
        logic [7:0]  regnum;
        logic        scl_d;
        logic        sda_d;
        out_word_t   pending[$];
        int          errors;
        int          bytes_seen;
        int          reads_done;
        int          nacks_seen;

        function new();
            hold_ticks = DELAY_RESET;
            ph = PH_IDLE;
            step = 0;
            bits = 0;
            shreg = 0;
            remaining = 0;
            hold_cnt = 0;
            dev = 0;
            regnum = 0;
            scl_d = 1;
            sda_d = 1;
            errors = 0;
            bytes_seen = 0;
            reads_done = 0;
            nacks_seen = 0;
        endfunction

        function void set_hold(logic [15:0] v);
            hold_ticks = v;
        endfunction

        function void drive_lines();
            logic b;
            b = shreg[7];
            case (ph)
                PH_START, PH_RSTART:
                begin
                    scl_d = 1;
                    sda_d = (step == 0);
                end
                PH_ADDR_W, PH_REG, PH_ADDR_R:
                begin
                    scl_d = (step == 1);
                    sda_d = (step == 2 && bits == 7) ? 1'b1 : b;
                end
                PH_ACK1, PH_ACK1_NACK, PH_ACK2, PH_ACK3, PH_READ:
                begin
                    scl_d = (step == 0);
                    sda_d = 1;
                end
                PH_RACK:
                begin
                    scl_d = (step == 1);
                    sda_d = (remaining > 1) ? 1'b0 : 1'b1;
                end
                PH_STOP, PH_STOP_ERR:
                begin
                    scl_d = (step != 0);
                    sda_d = (step != 0);
                end
                default:
                begin
                    ph = PH_IDLE;
                    scl_d = 1;
                    sda_d = 1;
                end
            endcase
        endfunction

        function void load_byte(phase_t p, logic [7:0] v);
            ph = p;
            step = 0;
            bits = 0;
            shreg = v;
        endfunction

        function void end_of_hold(logic sda, inout out_word_t r);
            logic [2:0] s;
            s = step;
            case (ph)
                PH_START, PH_RSTART:
                begin
                    if (s == 0)
                        step = 1;
                    else if (ph == PH_START)
                        load_byte(PH_ADDR_W, {dev, 1'b0});
                    else
                        load_byte(PH_ADDR_R, {dev, 1'b1});
                end
                PH_ADDR_W, PH_REG, PH_ADDR_R:
                begin
                    if (s < 2)
                        step = s + 3'd1;
                    else
                    begin
                        shreg = shreg << 1;
                        bits = bits + 4'd1;
                        step = 0;
                        if (bits >= 8)
                        begin
                            bits = 0;
                            ph = (ph == PH_ADDR_W) ? PH_ACK1 :
                                 (ph == PH_REG) ? PH_ACK2 : PH_ACK3;
                        end
                    end
                end
                PH_ACK1:
                begin
                    if (s == 0)
                    begin
                        step = 1;
                        if (sda)
                            ph = PH_ACK1_NACK;
                    end
                    else
                        load_byte(PH_REG, regnum);
                end
                PH_ACK1_NACK:
                begin
                    ph = PH_STOP_ERR;
                    step = 0;
                end
                PH_ACK2:
                begin
                    if (s == 0)
                        step = 1;
                    else
                    begin
                        ph = PH_RSTART;
                        step = 0;
                    end
                end
                PH_ACK3:
                begin
                    if (s == 0)
                        step = 1;
                    else if (remaining == 0)
                    begin
                        ph = PH_STOP;
                        step = 0;
                    end
                    else
                        load_byte(PH_READ, 8'h00);
                end
                PH_READ:
                begin
                    if (s == 0)
                    begin
                        shreg = {shreg[6:0], sda};
                        bits = bits + 4'd1;
                        if (bits >= 8)
                        begin
                            r.rx_byte = shreg;
                            r.byte_valid = 1;
                            r.last_byte = (remaining == 1);
                        end
                        step = 1;
                    end
                    else if (bits >= 8)
                    begin
                        ph = PH_RACK;
                        step = 0;
                    end
                    else
                        step = 0;
                end
                PH_RACK:
                begin
                    if (s < 2)
                        step = s + 3'd1;
                    else
                    begin
                        remaining = remaining - 8'd1;
                        if (remaining == 0)
                        begin
                            ph = PH_STOP;
                            step = 0;
                        end
                        else
                            load_byte(PH_READ, 8'h00);
                    end
                end
                PH_STOP, PH_STOP_ERR:
                begin
                    if (s == 0)
                        step = 1;
                    else
                    begin
                        r.done_res = 1;
                        r.nack_error = (ph == PH_STOP_ERR);
                        ph = PH_IDLE;
                        step = 0;
                        bits = 0;
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                    step = 0;
                end
            endcase
            drive_lines();
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            logic [15:0] lim;
            r = '0;
            lim = (hold_ticks == 0) ? 16'd1 : hold_ticks;
            if (w.req_type == REQ_START)
            begin
                if (ph == PH_IDLE)
                begin
                    dev = w.dev_addr;
                    regnum = w.reg_addr;
                    remaining = w.read_len;
                    ph = PH_START;
                    step = 0;
                    bits = 0;
                    shreg = 0;
                    hold_cnt = 0;
                    drive_lines();
                end
                r.scl_out = scl_d;
                r.sda_out = sda_d;
            end
            else
            begin
                r.scl_out = scl_d;
                r.sda_out = sda_d;
                if (ph != PH_IDLE)
                begin
                    hold_cnt = hold_cnt + 16'd1;
                    if (hold_cnt >= lim || hold_cnt == 0)
                    begin
                        hold_cnt = 0;
                        end_of_hold(w.sda_in, r);
                    end
                end
            end
            r.busy_res = (ph != PH_IDLE);
            pending.push_back(r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.byte_valid)
                bytes_seen++;
            if (got.done_res)
                reads_done++;
            if (got.nack_error)
                nacks_seen++;
            if (got !== exp)
            begin
                errors++;
                $display({"%0t: mismatch expected scl=%b sda=%b busy=%b rx=%h bv=%b",
                          " last=%b done=%b nack=%b"},
                         $time, exp.scl_out, exp.sda_out, exp.busy_res, exp.rx_byte,
                         exp.byte_valid, exp.last_byte, exp.done_res, exp.nack_error);
                $display({"%0t:          actual   scl=%b sda=%b busy=%b rx=%h bv=%b",
                          " last=%b done=%b nack=%b"},
                         $time, got.scl_out, got.sda_out, got.busy_res, got.rx_byte,
                         got.byte_valid, got.last_byte, got.done_res, got.nack_error);
            end
        endfunction
    endclass

    i2c_read_scoreboard sb;
    int idle_cycles;
    int words_sent;
    bit fast_phase;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("i2c_master_register_read_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.data);
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_word(in_ch.data);
    end

    // Result side: random stalls per word.
    initial
    begin
        int gap;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            gap = fast_phase ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hold(logic [15:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_hold(v);
    endtask

    function automatic in_word_t start_word(logic [6:0] a, logic [7:0] r, logic [7:0] n);
        in_word_t w;
        w = $bits(in_word_t)'($urandom);
        w.req_type = REQ_START;
        w.dev_addr = a;
        w.reg_addr = r;
        w.read_len = n;
        return w;
    endfunction

    // ack_mode: 0 always ack address, 1 nack address, 2 random sda
    task automatic run_read(in_word_t st, int ack_mode, int max_words);
        in_word_t w;
        int k;
        send_word(st);
        k = 0;
        while (k < max_words && (k == 0 || sb.ph != PH_IDLE || !sb.pending.size()))
        begin
            w = $bits(in_word_t)'($urandom);
            w.req_type = REQ_TICK;
            if (sb.ph == PH_ACK1 && ack_mode != 2)
                w.sda_in = (ack_mode == 1);
            else if ($urandom_range(0, 30) == 0)
                w.req_type = REQ_START;
            send_word(w);
            k++;
            if (sb.ph == PH_IDLE && sb.pending.size() <= 1)
                break;
        end
    endtask

    initial
    begin
        in_word_t w;
        int n;
        sb = new();
        words_sent = 0;
        fast_phase = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: idle ticks, address extremes, zero length, nack, delay 1 and delay 0
        w = '0;
        send_word(w);
        w.sda_in = 1;
        send_word(w);
        write_hold(16'd1);
        run_read(start_word(7'h7F, 8'hFF, 8'd2), 0, 400);
        run_read(start_word(7'h00, 8'h00, 8'd0), 0, 400);
        run_read(start_word(7'h55, 8'hAA, 8'd1), 1, 400);
        write_hold(16'd0);
        run_read(start_word(7'h2A, 8'h55, 8'd255), 2, 120);
        drain();
        write_hold(16'd2);

        // long delay: the words stay inside the first hold, short of the counter wrap
        write_hold(16'hFFFF);
        for (n = 0; n < 20; n++)
        begin
            w = $bits(in_word_t)'($urandom);
            w.req_type = (n == 0) ? REQ_START : REQ_TICK;
            send_word(w);
        end
        drain();
        write_hold(16'd1);
        run_read(start_word(7'h01, 8'h01, 8'd0), 0, 100);
        run_read(start_word(7'h10, 8'h20, 8'd1), 0, 400);

        // random part over several hold settings
        n = 0;
        while (words_sent < 1300)
        begin
            if (n % 4 == 0)
                write_hold(16'($urandom_range(0, 3)));
            fast_phase = (n % 5 == 3);
            run_read(start_word(7'($urandom), 8'($urandom), 8'($urandom_range(0, 3))),
                     ($urandom_range(0, 5) == 0) ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0),
                     300);
            n++;
        end
        fast_phase = 0;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d words over %0d reads: %0d bytes received, %0d reads done, %0d nacks.",
                 words_sent, n, sb.bytes_seen, sb.reads_done, sb.nacks_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("i2c_master_register_read_unit regression: pass");
        else
            $display("i2c_master_register_read_unit regression: fail");
        $finish;
    end
endmodule
